>>> hdl/bte_pkg.sv
// ----------------------------------------------------------------------------
// bte_pkg: shared definitions for the bigram transition estimator
// request codes, fixed field widths and default parameter values
// ----------------------------------------------------------------------------
package bte_pkg;

   // request codes carried on req_type
   localparam logic [1:0] REQ_START  = 2'd0;
   localparam logic [1:0] REQ_SYMBOL = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   // fixed field widths
   localparam int REQ_TYPE_BITS  = 2;
   localparam int SYM_BITS       = 6;
   localparam int ALPHA_BITS     = 7;
   localparam int FRAC_BITS      = 16;
   localparam int Q_BITS         = FRAC_BITS + 1;
   localparam int OUT_COUNT_BITS = 32;

   localparam logic [ALPHA_BITS-1:0]     ALPHA_RESET   = 7'd52;
   localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = 32'hFFFF_FFFF;

   // default parameter values
   localparam int DEFAULT_MAX_SYMBOLS = 64;
   localparam int DEFAULT_COUNT_BITS  = 32;

endpackage

>>> hdl/bte_ram.sv
// ----------------------------------------------------------------------------
// bte_ram: generic single write, single read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bte_div.sv
// ----------------------------------------------------------------------------
// bte_div: iterative fraction divider
// floor(num * 2^16 / den) for num <= den, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bte_div #(
   parameter int DEN_BITS = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DEN_BITS-1:0]        num,
   input  logic [DEN_BITS-1:0]        den,
   output logic                       done,
   output logic [bte_pkg::Q_BITS-1:0] quotient
);
   import bte_pkg::*;

   localparam int STEP_BITS = $clog2(Q_BITS);

   logic [DEN_BITS:0]    rem_ff, rem_in;
   logic [DEN_BITS-1:0]  den_ff, den_in;
   logic [Q_BITS-1:0]    quo_ff, quo_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_BITS:0]    trial;
   logic                 fits;

   // first step compares the numerator itself (integer bit), then shift in zeros
   always_comb begin
      trial = (step_ff == '0) ? rem_ff : {rem_ff[DEN_BITS-1:0], 1'b0};
      fits  = trial >= {1'b0, den_ff};
   end

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = den;
         quo_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? (trial - {1'b0, den_ff}) : trial;
         quo_in  = {quo_ff[Q_BITS-2:0], fits};
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(Q_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/bigram_transition_estimator.sv
// ----------------------------------------------------------------------------
// bigram_transition_estimator: add-one smoothed bigram transition table
// counts adjacent symbol pairs and answers smoothed transition probabilities
// ----------------------------------------------------------------------------
// Usage: after reset and after every start transfer the block sweeps both
// count memories to zero, one pair entry per cycle, 2^(2*clog2(MAX_SYMBOLS))
// entries (4096 at the default of 64 symbols); req_ready stays low meanwhile,
// csr writes are taken at any time. A symbol transfer that counts a pair goes
// through the accept, a memory read and a read-modify-write; one that counts
// nothing is done at the accept. A read transfer goes through the accept, the
// fetch of the pair count and row total, the bit-serial divider (17 quotient
// bits of the Q1.16 fraction, one per cycle, then its done flag) and the load
// of the result register, which waits while an earlier result still waits
// for rsp_ready. Out-of-range reads skip the memories and the divider.
// A result waits in the output register while further symbol items go in.
// ----------------------------------------------------------------------------
module bigram_transition_estimator #(
   parameter int MAX_SYMBOLS = bte_pkg::DEFAULT_MAX_SYMBOLS,
   parameter int COUNT_BITS  = bte_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [bte_pkg::ALPHA_BITS-1:0]     csr_wr_data,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bte_pkg::REQ_TYPE_BITS-1:0]  req_type,
   input  logic [bte_pkg::SYM_BITS-1:0]       req_sym_index,
   input  logic                               req_sym_known,
   input  logic [bte_pkg::SYM_BITS-1:0]       req_row_index,
   input  logic [bte_pkg::SYM_BITS-1:0]       req_col_index,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bte_pkg::Q_BITS-1:0]         rsp_probability,
   output logic [bte_pkg::OUT_COUNT_BITS-1:0] rsp_smoothed_count,
   output logic                               rsp_out_of_range
);
   import bte_pkg::*;

   localparam int IDX_BITS   = $clog2(MAX_SYMBOLS);
   localparam int PAIR_BITS  = 2 * IDX_BITS;
   localparam int PAIR_DEPTH = 2 ** PAIR_BITS;
   localparam int ROW_DEPTH  = 2 ** IDX_BITS;
   localparam int DEN_BITS   = COUNT_BITS + 1;
   localparam int WIDE_BITS  = DEN_BITS + OUT_COUNT_BITS;

   // sequencer states
   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_ACCESS   = 3'd2;
   localparam logic [2:0] ST_SYM_WR   = 3'd3;
   localparam logic [2:0] ST_RD_CALC  = 3'd4;
   localparam logic [2:0] ST_DIV_WAIT = 3'd5;
   localparam logic [2:0] ST_RESULT   = 3'd6;

   // control state
   logic [2:0]            state_ff, state_in;
   logic [PAIR_BITS-1:0]  sweep_ff, sweep_in;
   logic [IDX_BITS-1:0]   prev_sym_ff, prev_sym_in;
   logic                  prev_known_ff, prev_known_in;
   logic [ALPHA_BITS-1:0] alpha_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   // item payload held across the sequence
   logic [PAIR_BITS-1:0]      pair_addr_ff, pair_addr_in;
   logic                      is_read_ff, is_read_in;
   logic                      oor_ff, oor_in;
   logic [OUT_COUNT_BITS-1:0] count_ff, count_in;

   // response register
   logic [Q_BITS-1:0]         rsp_prob_ff, rsp_prob_in;
   logic [OUT_COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                      rsp_oor_ff, rsp_oor_in;

   // memories
   logic                  pair_we, row_we;
   logic [PAIR_BITS-1:0]  pair_waddr;
   logic [IDX_BITS-1:0]   row_waddr, row_addr;
   logic [COUNT_BITS-1:0] pair_wdata, row_wdata, pair_rd, row_rd;

   // arithmetic
   logic [ALPHA_BITS-1:0] size_eff;
   logic                  sym_in_alpha;
   logic                  read_oor;
   logic [DEN_BITS-1:0]   num_raw, num_clamp, den;
   logic [WIDE_BITS-1:0]  num_wide;
   logic                  div_start, div_done;
   logic [Q_BITS-1:0]     div_quotient;

   // effective alphabet size: zero acts as one, large values clip to the table
   always_comb begin
      if (alpha_ff == '0) begin
         size_eff = ALPHA_BITS'(1);
      end else if (32'(alpha_ff) > MAX_SYMBOLS) begin
         size_eff = ALPHA_BITS'(MAX_SYMBOLS);
      end else begin
         size_eff = alpha_ff;
      end
   end

   assign sym_in_alpha = req_sym_known && ({1'b0, req_sym_index} < size_eff);
   assign read_oor     = ({1'b0, req_row_index} >= size_eff) ||
                         ({1'b0, req_col_index} >= size_eff);

   // smoothed numerator and denominator from the fetched count and row total
   assign num_raw   = {1'b0, pair_rd} + DEN_BITS'(1);
   assign den       = DEN_BITS'(size_eff) + {1'b0, row_rd};
   assign num_clamp = (num_raw > den) ? den : num_raw;
   assign num_wide  = WIDE_BITS'(num_clamp);

   assign row_addr = pair_addr_ff[PAIR_BITS-1 -: IDX_BITS];

   // memory write side: zero sweep or saturating increment
   always_comb begin
      pair_we    = 1'b0;
      row_we     = 1'b0;
      pair_waddr = pair_addr_ff;
      row_waddr  = row_addr;
      pair_wdata = (pair_rd == '1) ? pair_rd : pair_rd + COUNT_BITS'(1);
      row_wdata  = (row_rd == '1) ? row_rd : row_rd + COUNT_BITS'(1);
      if (state_ff == ST_CLEAR) begin
         pair_we    = 1'b1;
         row_we     = 1'b1;
         pair_waddr = sweep_ff;
         row_waddr  = sweep_ff[PAIR_BITS-1 -: IDX_BITS];
         pair_wdata = '0;
         row_wdata  = '0;
      end else if (state_ff == ST_SYM_WR) begin
         pair_we = 1'b1;
         row_we  = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      prev_sym_in   = prev_sym_ff;
      prev_known_in = prev_known_ff;
      pair_addr_in  = pair_addr_ff;
      is_read_in    = is_read_ff;
      oor_in        = oor_ff;
      count_in      = count_ff;
      div_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_prob_in   = rsp_prob_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_oor_in    = rsp_oor_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + PAIR_BITS'(1);
            if (sweep_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_type)
                  REQ_START: begin
                     state_in      = ST_CLEAR;
                     sweep_in      = '0;
                     prev_sym_in   = '0;
                     prev_known_in = 1'b0;
                  end
                  REQ_SYMBOL: begin
                     // pair address uses the previous symbol before it moves on
                     pair_addr_in  = {prev_sym_ff, IDX_BITS'(req_sym_index)};
                     is_read_in    = 1'b0;
                     prev_sym_in   = sym_in_alpha ? IDX_BITS'(req_sym_index) : '0;
                     prev_known_in = sym_in_alpha;
                     if (sym_in_alpha && prev_known_ff) begin
                        state_in = ST_ACCESS;
                     end
                  end
                  REQ_READ: begin
                     is_read_in = 1'b1;
                     oor_in     = read_oor;
                     if (read_oor) begin
                        state_in = ST_RESULT;
                     end else begin
                        pair_addr_in = {IDX_BITS'(req_row_index),
                                        IDX_BITS'(req_col_index)};
                        state_in     = ST_ACCESS;
                     end
                  end
                  default: begin
                     // unused request code: dropped
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            state_in = is_read_ff ? ST_RD_CALC : ST_SYM_WR;
         end
         ST_SYM_WR: begin
            state_in = ST_IDLE;
         end
         ST_RD_CALC: begin
            div_start = 1'b1;
            count_in  = (num_wide > WIDE_BITS'(OUT_COUNT_MAX)) ?
                        OUT_COUNT_MAX : num_wide[OUT_COUNT_BITS-1:0];
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // load once the output register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_prob_in  = oor_ff ? '0 : div_quotient;
               rsp_count_in = oor_ff ? '0 : count_ff;
               rsp_oor_in   = oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_ff      <= '0;
         prev_sym_ff   <= '0;
         prev_known_ff <= 1'b0;
         alpha_ff      <= ALPHA_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         prev_sym_ff   <= prev_sym_in;
         prev_known_ff <= prev_known_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            alpha_ff <= csr_wr_data;
         end
      end
      pair_addr_ff <= pair_addr_in;
      is_read_ff   <= is_read_in;
      oor_ff       <= oor_in;
      count_ff     <= count_in;
      rsp_prob_ff  <= rsp_prob_in;
      rsp_count_ff <= rsp_count_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   bte_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (PAIR_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_we),
      .wr_addr (pair_waddr),
      .wr_data (pair_wdata),
      .rd_addr (pair_addr_ff),
      .rd_data (pair_rd)
   );

   bte_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (ROW_DEPTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_addr (row_addr),
      .rd_data (row_rd)
   );

   bte_div #(
      .DEN_BITS (DEN_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_clamp),
      .den      (den),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probability    = rsp_prob_ff;
   assign rsp_smoothed_count = rsp_count_ff;
   assign rsp_out_of_range   = rsp_oor_ff;

   // a start transfer always launches a full sweep from entry zero
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_START)
      |=> (state_ff == ST_CLEAR) && (sweep_ff == '0))
      else $error("start transfer did not begin a clearing sweep");

   // memories are written only by the sweep or a pair update
   assert property (@(posedge clock) disable iff (reset)
      pair_we |-> (state_ff == ST_CLEAR) || (state_ff == ST_SYM_WR))
      else $error("count memory written outside sweep or update");

   // the divider only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished with no read waiting");

   // a new result is only loaded from the result state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESULT)
      else $error("response raised outside the result state");

   // out-of-range results carry zero payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range
      |-> (rsp_probability == '0) && (rsp_smoothed_count == '0))
      else $error("out-of-range response with non-zero payload");

endmodule

>>> tb/bigram_transition_estimator_tb.sv
// ----------------------------------------------------------------------------
// bigram_transition_estimator_tb: self-checking bench for the bigram estimator
// drives start, symbol, read and unused-code transfers with random gaps on both channels,
// keeps its own copy of the pair counts and row totals, and compares every
// read result field by field against the entry it predicts
// ----------------------------------------------------------------------------
module bigram_transition_estimator_tb;
   import bte_pkg::*;

   // request code that the block must ignore
   localparam logic [REQ_TYPE_BITS-1:0] REQ_UNUSED = 2'd3;

   localparam int NUM_SYMBOLS   = DEFAULT_MAX_SYMBOLS;
   localparam int TALLY_BITS    = DEFAULT_COUNT_BITS;
   // room for a read or a counting symbol to finish, with plenty to spare
   localparam int SETTLE_CYCLES = 40;
   // watchdog limit on the whole run, clearing passes included
   localparam int CYCLE_LIMIT   = 1_000_000;

   typedef struct packed {
      logic [Q_BITS-1:0]         probability;
      logic [OUT_COUNT_BITS-1:0] smoothed_count;
      logic                      out_of_range;
   } trans_entry_type;

   logic clock;
   logic reset = 1'b1;

   logic                     csr_wr_en     = 1'b0;
   logic [ALPHA_BITS-1:0]    csr_wr_data   = '0;
   logic                     req_valid     = 1'b0;
   logic                     req_ready;
   logic [REQ_TYPE_BITS-1:0] req_type      = REQ_START;
   logic [SYM_BITS-1:0]      req_sym_index = '0;
   logic                     req_sym_known = 1'b0;
   logic [SYM_BITS-1:0]      req_row_index = '0;
   logic [SYM_BITS-1:0]      req_col_index = '0;
   logic                     rsp_valid;
   logic                     rsp_ready     = 1'b0;
   logic [Q_BITS-1:0]        rsp_probability;
   logic [OUT_COUNT_BITS-1:0] rsp_smoothed_count;
   logic                     rsp_out_of_range;

   bigram_transition_estimator dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_sym_index      (req_sym_index),
      .req_sym_known      (req_sym_known),
      .req_row_index      (req_row_index),
      .req_col_index      (req_col_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_probability    (rsp_probability),
      .rsp_smoothed_count (rsp_smoothed_count),
      .rsp_out_of_range   (rsp_out_of_range)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // local copy of the transition counts
   // ------------------------------------------------------------------------
   logic [TALLY_BITS-1:0] pair_tally [0:NUM_SYMBOLS*NUM_SYMBOLS-1];
   logic [TALLY_BITS-1:0] row_tally  [0:NUM_SYMBOLS-1];
   logic [SYM_BITS-1:0]   prev_sym;
   logic                  prev_known;
   logic [ALPHA_BITS-1:0] alphabet_q;

   // read results still to come back, oldest first
   trans_entry_type awaited_entries [$];

   int  fail_count = 0;
   int  cycle_count = 0;
   bit  no_idle = 1'b0;
   int  stall_left = 0;

   // register value to the number of symbols it stands for: 0 acts as 1,
   // anything above the table size acts as the table size
   function automatic int active_symbols(input logic [ALPHA_BITS-1:0] value);
      if (value == '0)
         return 1;
      if (value > NUM_SYMBOLS)
         return NUM_SYMBOLS;
      return int'(value);
   endfunction

   function automatic logic [TALLY_BITS-1:0] bump(input logic [TALLY_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // mostly short gaps, now and then a long one, none in a busy stretch
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic clear_counts();
      foreach (pair_tally[i]) pair_tally[i] = '0;
      foreach (row_tally[i]) row_tally[i] = '0;
      prev_sym   = '0;
      prev_known = 1'b0;
   endtask

   // apply one accepted request to the local counts; reads queue their entry
   task automatic apply_to_counts(input logic [REQ_TYPE_BITS-1:0] kind,
                                  input logic [SYM_BITS-1:0] sym,
                                  input logic sym_ok,
                                  input logic [SYM_BITS-1:0] row,
                                  input logic [SYM_BITS-1:0] col);
      int size;
      bit known;
      longint unsigned num;
      longint unsigned den;
      longint unsigned frac;
      trans_entry_type ent;
      size = active_symbols(alphabet_q);
      case (kind)
         REQ_START: begin
            clear_counts();
         end
         REQ_SYMBOL: begin
            // a known flag on an index beyond the alphabet counts as unknown
            known = sym_ok && (sym < size);
            if (known && prev_known) begin
               pair_tally[{prev_sym, sym}] = bump(pair_tally[{prev_sym, sym}]);
               row_tally[prev_sym]         = bump(row_tally[prev_sym]);
            end
            prev_sym   = known ? sym : '0;
            prev_known = known;
         end
         REQ_READ: begin
            if (row >= size || col >= size) begin
               ent.probability    = '0;
               ent.smoothed_count = '0;
               ent.out_of_range   = 1'b1;
            end else begin
               num = 64'(pair_tally[{row, col}]);
               num = num + 1;
               den = 64'(row_tally[row]);
               den = den + 64'(size);
               if (num > den)
                  num = den;
               frac = (num << FRAC_BITS) / den;
               ent.probability    = frac[Q_BITS-1:0];
               ent.smoothed_count = (num > OUT_COUNT_MAX) ? OUT_COUNT_MAX
                                                          : num[OUT_COUNT_BITS-1:0];
               ent.out_of_range   = 1'b0;
            end
            awaited_entries = {awaited_entries, ent};
         end
         default: begin
            // unused code: nothing changes
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // request side: one transfer, valid held until it is taken
   // ------------------------------------------------------------------------
   task automatic send_req(input logic [REQ_TYPE_BITS-1:0] kind,
                           input logic [SYM_BITS-1:0] sym,
                           input logic sym_ok,
                           input logic [SYM_BITS-1:0] row,
                           input logic [SYM_BITS-1:0] col);
      int gap;
      gap = idle_len();
      // valid is only dropped when a gap follows, so it never toggles in a step
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_sym_index <= sym;
      req_sym_known <= sym_ok;
      req_row_index <= row;
      req_col_index <= col;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_to_counts(kind, sym, sym_ok, row, col);
   endtask

   // unused fields of each transfer carry random bits
   task automatic send_start();
      send_req(REQ_START, SYM_BITS'($urandom), 1'($urandom),
               SYM_BITS'($urandom), SYM_BITS'($urandom));
   endtask

   task automatic send_symbol(input logic [SYM_BITS-1:0] sym, input logic sym_ok);
      send_req(REQ_SYMBOL, sym, sym_ok, SYM_BITS'($urandom), SYM_BITS'($urandom));
   endtask

   task automatic send_read(input logic [SYM_BITS-1:0] row, input logic [SYM_BITS-1:0] col);
      send_req(REQ_READ, SYM_BITS'($urandom), 1'($urandom), row, col);
   endtask

   // register writes only with the block idle: no read outstanding, time
   // for a last counting symbol to finish its read-modify-write, and any
   // clearing pass over
   task automatic write_alphabet(input logic [ALPHA_BITS-1:0] value);
      req_valid <= 1'b0;
      while (awaited_entries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (!req_ready) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      alphabet_q = value;
   endtask

   // ------------------------------------------------------------------------
   // response side: random back-pressure and the result check
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      int n;
      trans_entry_type ent;
      if (rsp_valid && rsp_ready) begin
         if (awaited_entries.size() == 0) begin
            $error("result transfer with no read outstanding");
            fail_count++;
         end else begin
            ent = awaited_entries.pop_front();
            if (rsp_probability !== ent.probability) begin
               $error("probability: expected %0d, actual %0d",
                      ent.probability, rsp_probability);
               fail_count++;
            end
            if (rsp_smoothed_count !== ent.smoothed_count) begin
               $error("smoothed_count: expected %0d, actual %0d",
                      ent.smoothed_count, rsp_smoothed_count);
               fail_count++;
            end
            if (rsp_out_of_range !== ent.out_of_range) begin
               $error("out_of_range: expected %0d, actual %0d",
                      ent.out_of_range, rsp_out_of_range);
               fail_count++;
            end
         end
      end
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         n = idle_len();
         rsp_ready  <= (n == 0);
         stall_left <= (n > 0) ? n - 1 : 0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // default alphabet of 52, all counts zero, edges of the index range
   task automatic test_reset_state();
      send_read(6'd0, 6'd0);
      send_read(6'd51, 6'd51);
      send_read(6'd52, 6'd0);
      send_read(6'd0, 6'd63);
      // unused code, the read after it shows nothing moved
      send_req(REQ_UNUSED, 6'h3f, 1'b1, 6'h2a, 6'h15);
      send_read(6'd0, 6'd0);
   endtask

   // pair counting, unknown symbols breaking the chain, single-symbol text
   task automatic test_text_counting();
      send_start();
      send_symbol(6'd0, 1'b1);
      send_symbol(6'd1, 1'b1);
      send_symbol(6'd1, 1'b1);
      send_symbol(6'd5, 1'b0);
      send_symbol(6'd2, 1'b1);
      // flagged known but beyond the alphabet
      send_symbol(6'd60, 1'b1);
      send_symbol(6'd3, 1'b1);
      send_symbol(6'd3, 1'b1);
      send_read(6'd0, 6'd1);
      send_read(6'd1, 6'd1);
      send_read(6'd3, 6'd3);
      send_read(6'd2, 6'd3);
      send_start();
      send_symbol(6'd7, 1'b1);
      send_read(6'd7, 6'd7);
   endtask

   // smallest and largest alphabets, out-of-range register values, and a
   // size change in mid text with the previous symbol kept
   task automatic test_alphabet_extremes();
      write_alphabet(7'd1);
      send_start();
      send_symbol(6'd0, 1'b1);
      send_symbol(6'd0, 1'b1);
      send_symbol(6'd0, 1'b1);
      // count equals row total here, so the fraction is exactly one
      send_read(6'd0, 6'd0);
      write_alphabet(7'd0);
      send_read(6'd0, 6'd0);
      send_read(6'd1, 6'd0);
      write_alphabet(7'd64);
      send_symbol(6'd63, 1'b1);
      send_symbol(6'd63, 1'b1);
      send_read(6'd63, 6'd63);
      write_alphabet(7'd127);
      send_read(6'd63, 6'd63);
      send_read(6'd0, 6'd63);
   endtask

   // one random text under a given alphabet; mostly well-formed symbols from
   // a small hot set so pairs repeat, plus reads, noise and rare restarts
   task automatic random_text(input logic [ALPHA_BITS-1:0] alpha_value, input int items);
      int size;
      int span;
      int r;
      write_alphabet(alpha_value);
      size    = active_symbols(alpha_value);
      no_idle = ($urandom_range(0, 3) == 0);
      // half the time the old counts carry over into the new alphabet
      if ($urandom_range(0, 1) == 1)
         send_start();
      repeat (items) begin
         r    = $urandom_range(0, 99);
         span = (size < 6 || $urandom_range(0, 3) == 0) ? size : 6;
         if (r < 2) begin
            send_start();
         end else if (r < 5) begin
            send_req(REQ_UNUSED, SYM_BITS'($urandom), 1'($urandom),
                     SYM_BITS'($urandom), SYM_BITS'($urandom));
         end else if (r < 58) begin
            if ($urandom_range(0, 9) == 0)
               send_symbol(SYM_BITS'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            else
               send_symbol(SYM_BITS'($urandom_range(0, span - 1)), 1'b1);
         end else begin
            if ($urandom_range(0, 7) == 0)
               send_read(SYM_BITS'($urandom_range(0, 63)),
                         SYM_BITS'($urandom_range(0, 63)));
            else
               send_read(SYM_BITS'($urandom_range(0, span - 1)),
                         SYM_BITS'($urandom_range(0, span - 1)));
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_texts();
      random_text(ALPHA_RESET, 50);
      random_text(7'd1, 40);
      random_text(7'd64, 50);
      random_text(7'd127, 40);
      random_text(7'd0, 30);
      random_text(ALPHA_BITS'($urandom_range(2, 12)), 60);
      random_text(ALPHA_BITS'($urandom_range(1, 127)), 50);
      random_text(ALPHA_BITS'($urandom_range(65, 127)), 40);
      random_text(ALPHA_BITS'($urandom_range(2, 8)), 60);
   endtask

   initial begin
      alphabet_q = ALPHA_RESET;
      clear_counts();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_text_counting();
      test_alphabet_extremes();
      test_random_texts();

      // drain: every read back, then room for a trailing symbol update
      req_valid <= 1'b0;
      while (awaited_entries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
